[src/iasdr_pkg.sv]
package iasdr_pkg;

   localparam int unsigned LatencyCycles = 4;

   localparam logic [63:0] SignBit    = 64'h8000_0000_0000_0000;
   localparam logic [63:0] QuietBit   = 64'h0008_0000_0000_0000;
   localparam logic [63:0] DefaultNan = 64'hFFF8_0000_0000_0000;
   localparam logic [63:0] MaxFinite  = 64'h7FEF_FFFF_FFFF_FFFF;
   localparam logic [63:0] InfBits    = 64'h7FF0_0000_0000_0000;

   localparam logic OpAdd = 1'b0;
   localparam logic OpSub = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [63:0] a_low;
      logic [63:0] a_high;
      logic [63:0] b_low;
      logic [63:0] b_high;
   } req_word_type;

   typedef struct packed {
      logic [63:0] result_low;
      logic [63:0] result_high;
   } rsp_word_type;

endpackage

[src/iasdr_fp_add.sv]
module iasdr_fp_add (
   input  logic        clock,
   input  logic [63:0] x,
   input  logic [63:0] y,
   input  logic        neg_y,
   input  logic        down,
   output logic [63:0] z
);
   import iasdr_pkg::*;

   // Stage 1: unpack, special operands, magnitude ordering.
   logic        s1_spec_in, s1_spec_ff;
   logic [63:0] s1_val_in, s1_val_ff;
   logic        s1_sb_in, s1_sb_ff, s1_ss_in, s1_ss_ff, s1_down_ff;
   logic [10:0] s1_eb_in, s1_eb_ff, s1_d_in, s1_d_ff;
   logic [52:0] s1_mb_in, s1_mb_ff, s1_ms_in, s1_ms_ff;

   logic [63:0] y2;
   logic [10:0] exr, eyr, ex, ey;
   logic [52:0] mx, my;
   logic        nan_x, nan_y, inf_x, inf_y, x_big;

   always_comb begin
      y2    = y ^ (neg_y ? SignBit : 64'd0);
      exr   = x[62:52];
      eyr   = y[62:52];
      nan_x = (&exr) && (|x[51:0]);
      nan_y = (&eyr) && (|y[51:0]);
      inf_x = (&exr) && !(|x[51:0]);
      inf_y = (&eyr) && !(|y[51:0]);
      mx    = {exr != 11'd0, x[51:0]};
      my    = {eyr != 11'd0, y[51:0]};
      ex    = (exr == 11'd0) ? 11'd1 : exr;
      ey    = (eyr == 11'd0) ? 11'd1 : eyr;
      x_big = (ex > ey) || ((ex == ey) && (mx >= my));
      s1_spec_in = 1'b1;
      s1_val_in  = x;
      if (nan_x) begin
         s1_val_in = x | QuietBit;
      end else if (nan_y) begin
         s1_val_in = y | QuietBit;
      end else if (inf_x) begin
         s1_val_in = (inf_y && (x[63] != y2[63])) ? DefaultNan : x;
      end else if (inf_y) begin
         s1_val_in = y2;
      end else if (mx == 53'd0 && my == 53'd0) begin
         if (x[63] == y2[63]) begin
            s1_val_in = x;
         end else begin
            s1_val_in = down ? SignBit : 64'd0;
         end
      end else if (mx == 53'd0) begin
         s1_val_in = y2;
      end else if (my == 53'd0) begin
         s1_val_in = x;
      end else begin
         s1_spec_in = 1'b0;
      end
      if (x_big) begin
         s1_sb_in = x[63];
         s1_ss_in = y2[63];
         s1_eb_in = ex;
         s1_mb_in = mx;
         s1_ms_in = my;
         s1_d_in  = ex - ey;
      end else begin
         s1_sb_in = y2[63];
         s1_ss_in = x[63];
         s1_eb_in = ey;
         s1_mb_in = my;
         s1_ms_in = mx;
         s1_d_in  = ey - ex;
      end
   end

   always_ff @(posedge clock) begin
      s1_spec_ff <= s1_spec_in;
      s1_val_ff  <= s1_val_in;
      s1_sb_ff   <= s1_sb_in;
      s1_ss_ff   <= s1_ss_in;
      s1_eb_ff   <= s1_eb_in;
      s1_mb_ff   <= s1_mb_in;
      s1_ms_ff   <= s1_ms_in;
      s1_d_ff    <= s1_d_in;
      s1_down_ff <= down;
   end

   // Stage 2: alignment with sticky bit, then add or subtract.
   logic         s2_spec_in, s2_spec_ff, s2_s_ff, s2_down_ff;
   logic [63:0]  s2_val_in, s2_val_ff;
   logic [56:0]  s2_m_in, s2_m_ff;
   logic [10:0]  s2_e_ff;
   logic [5:0]   dd;
   logic [119:0] wide;
   logic [55:0]  al;

   always_comb begin
      dd   = (s1_d_ff > 11'd63) ? 6'd63 : s1_d_ff[5:0];
      wide = {s1_ms_ff, 3'b000, 64'd0} >> dd;
      al   = wide[119:64] | {55'd0, |wide[63:0]};
      if (s1_sb_ff == s1_ss_ff) begin
         s2_m_in = {1'b0, s1_mb_ff, 3'b000} + {1'b0, al};
      end else begin
         s2_m_in = {1'b0, s1_mb_ff, 3'b000} - {1'b0, al};
      end
      s2_spec_in = s1_spec_ff;
      s2_val_in  = s1_val_ff;
      if (!s1_spec_ff && s2_m_in == 57'd0) begin
         s2_spec_in = 1'b1;
         s2_val_in  = s1_down_ff ? SignBit : 64'd0;
      end
   end

   always_ff @(posedge clock) begin
      s2_spec_ff <= s2_spec_in;
      s2_val_ff  <= s2_val_in;
      s2_m_ff    <= s2_m_in;
      s2_e_ff    <= s1_eb_ff;
      s2_s_ff    <= s1_sb_ff;
      s2_down_ff <= s1_down_ff;
   end

   // Stage 3: carry-out correction and normalization.
   logic        s3_spec_ff, s3_s_ff, s3_down_ff;
   logic [63:0] s3_val_ff;
   logic [55:0] s3_m_in, s3_m_ff, m56;
   logic [11:0] s3_e_in, s3_e_ff, e2, lz, sh;

   always_comb begin
      if (s2_m_ff[56]) begin
         m56 = {s2_m_ff[56:2], s2_m_ff[1] | s2_m_ff[0]};
         e2  = {1'b0, s2_e_ff} + 12'd1;
      end else begin
         m56 = s2_m_ff[55:0];
         e2  = {1'b0, s2_e_ff};
      end
      lz = 12'd56;
      for (int i = 0; i < 56; i++) begin
         if (m56[i]) begin
            lz = 12'(55 - i);
         end
      end
      sh      = (lz < e2 - 12'd1) ? lz : e2 - 12'd1;
      s3_m_in = m56 << sh[5:0];
      s3_e_in = e2 - sh;
   end

   always_ff @(posedge clock) begin
      s3_spec_ff <= s2_spec_ff;
      s3_val_ff  <= s2_val_ff;
      s3_m_ff    <= s3_m_in;
      s3_e_ff    <= s3_e_in;
      s3_s_ff    <= s2_s_ff;
      s3_down_ff <= s2_down_ff;
   end

   // Stage 4: directed rounding and packing.
   logic [63:0] z_in, z_ff;
   logic [53:0] q;
   logic [11:0] e4;
   logic        away;

   always_comb begin
      away = s3_s_ff ? s3_down_ff : !s3_down_ff;
      q    = {1'b0, s3_m_ff[55:3]} + {53'd0, away && (|s3_m_ff[2:0])};
      e4   = s3_e_ff;
      if (q[53]) begin
         q  = q >> 1;
         e4 = e4 + 12'd1;
      end
      if (s3_spec_ff) begin
         z_in = s3_val_ff;
      end else if (e4 >= 12'd2047) begin
         z_in = {s3_s_ff, 63'd0} | (away ? InfBits : MaxFinite);
      end else if (!q[52]) begin
         z_in = {s3_s_ff, 10'd0, q[52:0]};
      end else begin
         z_in = {s3_s_ff, e4[10:0], q[51:0]};
      end
   end

   always_ff @(posedge clock) begin
      z_ff <= z_in;
   end

   assign z = z_ff;

endmodule

[src/interval_add_sub_directed_rounding_core.sv]
// rsp_valid follows an accepted start through a valid shift register beside the adder stages.
// Throughput: one word per cycle; busy is always low, each bound has its own
// four-stage adder pipeline.
// Reset (synchronous, active high) clears the valid pipeline only.
// The receiver cannot stall, so results are never held back.
module interval_add_sub_directed_rounding_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  iasdr_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output iasdr_pkg::rsp_word_type rsp_word
);
   import iasdr_pkg::*;

   logic [LatencyCycles-1:0] valid_in, valid_ff;
   logic [63:0] lo_y, hi_y;
   logic        sub;

   assign busy = 1'b0;
   assign sub  = (req_word.operation == OpSub);
   assign lo_y = sub ? req_word.b_high : req_word.b_low;
   assign hi_y = sub ? req_word.b_low : req_word.b_high;

   iasdr_fp_add u_low (
      .clock (clock),
      .x     (req_word.a_low),
      .y     (lo_y),
      .neg_y (sub),
      .down  (1'b1),
      .z     (rsp_word.result_low)
   );

   iasdr_fp_add u_high (
      .clock (clock),
      .x     (req_word.a_high),
      .y     (hi_y),
      .neg_y (sub),
      .down  (1'b0),
      .z     (rsp_word.result_high)
   );

   assign valid_in = {valid_ff[LatencyCycles-2:0], start && !busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[LatencyCycles-1];

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted word did not produce a result after four cycles");

   a_low_nan_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (&rsp_word.result_low[62:52]) && (|rsp_word.result_low[51:0]))
      |-> rsp_word.result_low[51])
      else $error("lower bound NaN is not quiet");

   a_high_nan_quiet : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (&rsp_word.result_high[62:52]) && (|rsp_word.result_high[51:0]))
      |-> rsp_word.result_high[51])
      else $error("upper bound NaN is not quiet");

endmodule
